[rtl/upq_pkg.sv]
// Shared types and codes for the unsorted maximum priority queue.
`default_nettype none

package upq_pkg;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_PEEK    = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } entry_t;

endpackage

`default_nettype wire

[rtl/unsorted_max_priority_queue.sv]
// Top level of the unsorted maximum priority queue: sequencer, entry store and top cache.
//
//  channel  | handshake             | word
//  ---------+-----------------------+----------------------------------------------------
//  command  | start, busy           | command, item_value, item_priority
//  result   | done (one-cycle pulse)| status, top_valid, top_value, top_priority,
//           |                       | top_slot, entry_count
//
// Enqueue, peek, overflow and underflow answer the cycle after the word is taken, busy stays low.
// Dequeue closes up the slots above the removed entry, one slot a cycle through the store's
// single read and write port, then rescans the survivors one slot a cycle with a single
// signed comparator before the result is given.
// Reset empties the queue at once; the store itself is never cleared.
// The result cannot be held off: it is valid only while done is high.
`default_nettype none

module unsorted_max_priority_queue #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           command,
    input  wire logic signed [31:0]   item_value,
    input  wire logic signed [31:0]   item_priority,
    output logic                      done,
    output logic [1:0]                status,
    output logic                      top_valid,
    output logic signed [31:0]        top_value,
    output logic signed [31:0]        top_priority,
    output logic [AW-1:0]             top_slot,
    output logic [CW-1:0]             entry_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_SCAN
    } state_t;

    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          rd_idx_reg, rd_idx_next;
    logic [AW-1:0]          wr_idx_reg, wr_idx_next;
    logic                   wr_pend_reg, wr_pend_next;
    logic [CW-1:0]          scan_idx_reg, scan_idx_next;
    logic                   cmp_live_reg, cmp_live_next;
    logic [AW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic signed [31:0]     top_value_reg, top_value_next;
    logic signed [31:0]     top_prio_reg, top_prio_next;
    logic [AW-1:0]          top_slot_reg, top_slot_next;
    logic                   done_reg, done_next;
    upq_pkg::status_t       status_reg, status_next;
    logic signed [31:0]     cmp_operand;
    logic                   prio_wins;

    upq_pkg::entry_t        mem [DEPTH];
    upq_pkg::entry_t        rd_data_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [AW-1:0]          mem_raddr;
    upq_pkg::entry_t        mem_wdata;

    // Entry store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        wr_pend_next   = wr_pend_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_live_next  = cmp_live_reg;
        cmp_idx_next   = cmp_idx_reg;
        top_value_next = top_value_reg;
        top_prio_next  = top_prio_reg;
        top_slot_next  = top_slot_reg;
        status_next    = status_reg;
        done_next      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[AW-1:0];
        mem_raddr      = scan_idx_reg[AW-1:0];
        mem_wdata.value = item_value;
        mem_wdata.prio  = item_priority;
        // One comparator: the incoming priority while idle, the stored one while scanning.
        cmp_operand    = (state_reg == S_SCAN) ? rd_data_reg.prio : item_priority;
        prio_wins      = (cmp_operand > top_prio_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next = upq_pkg::ST_DONE;
                    case (command)
                        upq_pkg::CMD_ENQUEUE:
                        begin
                            done_next = 1'b1;
                            if (count_reg == FULL)
                            begin
                                status_next = upq_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                // Strictly greater: an earlier entry keeps a tie.
                                if (count_reg == '0 || prio_wins)
                                begin
                                    top_value_next = item_value;
                                    top_prio_next  = item_priority;
                                    top_slot_next  = count_reg[AW-1:0];
                                end
                            end
                        end
                        upq_pkg::CMD_DEQUEUE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = upq_pkg::ST_UNDERFLOW;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                rd_idx_next  = CW'(top_slot_reg) + 1'b1;
                                wr_pend_next = 1'b0;
                                state_next   = S_SHIFT;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                // Read slot i while writing the word read last cycle into slot i-2.
                mem_raddr = rd_idx_reg[AW-1:0];
                if (rd_idx_reg < count_reg)
                begin
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    wr_idx_next  = AW'(rd_idx_reg - 1'b1);
                    wr_pend_next = 1'b1;
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    if (!wr_pend_reg)
                    begin
                        count_next    = count_reg - 1'b1;
                        scan_idx_next = '0;
                        cmp_live_next = 1'b0;
                        if (count_reg == CW'(1))
                        begin
                            top_value_next = '0;
                            top_prio_next  = '0;
                            top_slot_next  = '0;
                            done_next      = 1'b1;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
                if (wr_pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_idx_reg;
                    mem_wdata = rd_data_reg;
                end
            end

            S_SCAN:
            begin
                mem_raddr = scan_idx_reg[AW-1:0];
                if (scan_idx_reg < count_reg)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    cmp_live_next = 1'b1;
                    cmp_idx_next  = scan_idx_reg[AW-1:0];
                end
                else
                begin
                    cmp_live_next = 1'b0;
                    if (!cmp_live_reg)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                if (cmp_live_reg)
                begin
                    if (cmp_idx_reg == '0 || prio_wins)
                    begin
                        top_value_next = rd_data_reg.value;
                        top_prio_next  = rd_data_reg.prio;
                        top_slot_next  = cmp_idx_reg;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            wr_pend_reg   <= 1'b0;
            scan_idx_reg  <= '0;
            cmp_live_reg  <= 1'b0;
            cmp_idx_reg   <= '0;
            top_value_reg <= '0;
            top_prio_reg  <= '0;
            top_slot_reg  <= '0;
            status_reg    <= upq_pkg::ST_DONE;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            wr_pend_reg   <= wr_pend_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_live_reg  <= cmp_live_next;
            cmp_idx_reg   <= cmp_idx_next;
            top_value_reg <= top_value_next;
            top_prio_reg  <= top_prio_next;
            top_slot_reg  <= top_slot_next;
            status_reg    <= status_next;
            done_reg      <= done_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign top_valid    = (count_reg != '0);
    assign top_value    = top_value_reg;
    assign top_priority = top_prio_reg;
    assign top_slot     = top_slot_reg;
    assign entry_count  = count_reg;

endmodule

`default_nettype wire

[rtl/upq_checker.sv]
// Port-level checks for the unsorted maximum priority queue, bound to the top level.
`default_nettype none

module upq_assertions #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 busy,
    input wire logic                 done,
    input wire logic [1:0]           status,
    input wire logic                 top_valid,
    input wire logic signed [31:0]   top_value,
    input wire logic signed [31:0]   top_priority,
    input wire logic [AW-1:0]        top_slot,
    input wire logic [CW-1:0]        entry_count
);

    // A word is reported only once the sequencer is free again.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (top_valid == (entry_count != '0)))
        else $error("top_valid disagrees with entry_count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !top_valid) |-> (top_value == '0 && top_priority == '0 && top_slot == '0))
        else $error("empty queue reports a non-zero top");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && top_valid) |-> (CW'(top_slot) < entry_count))
        else $error("top slot beyond occupancy");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == upq_pkg::ST_DONE || status == upq_pkg::ST_OVERFLOW
                  || status == upq_pkg::ST_UNDERFLOW))
        else $error("undefined status code");

endmodule

bind unsorted_max_priority_queue upq_assertions #(.DEPTH(DEPTH)) u_upq_assertions (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .top_valid    (top_valid),
    .top_value    (top_value),
    .top_priority (top_priority),
    .top_slot     (top_slot),
    .entry_count  (entry_count)
);

`default_nettype wire

[bench/upq_checker.sv]
// Checker for the priority queue: shadows the entry store, predicts every result, compares.
`default_nettype none

module upq_checker #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic [1:0]           command,
    input  wire logic signed [31:0]   item_value,
    input  wire logic signed [31:0]   item_priority,
    input  wire logic                 done,
    input  wire logic [1:0]           status,
    input  wire logic                 top_valid,
    input  wire logic signed [31:0]   top_value,
    input  wire logic signed [31:0]   top_priority,
    input  wire logic [AW-1:0]        top_slot,
    input  wire logic [CW-1:0]        entry_count,
    output int                        failures,
    output int                        pending,
    output int                        checked,
    output int                        overflows,
    output int                        underflows
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        upq_pkg::status_t   st;
        logic               valid;
        logic signed [31:0] value;
        logic signed [31:0] prio;
        logic [AW-1:0]      slot;
        logic [CW-1:0]      count;
    } top_report_t;

    upq_pkg::entry_t shadow_store [DEPTH];
    int unsigned     shadow_held = 0;
    top_report_t     awaited_reports [$];
    top_report_t     oldest;

    task automatic flag_mismatch(input string msg);
        failures++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %h, want %h", name, got, want));
    endtask

    // Highest priority among held entries; the lowest slot keeps a tie.
    function automatic int unsigned highest_slot();
        int unsigned best;
        best = 0;
        for (int unsigned i = 1; i < shadow_held; i++)
            if ($signed(shadow_store[AW'(i)].prio) > $signed(shadow_store[AW'(best)].prio))
                best = i;
        return best;
    endfunction

    function automatic top_report_t report_top(input upq_pkg::status_t st);
        top_report_t r;
        int unsigned best;
        r.st    = st;
        r.count = CW'(shadow_held);
        if (shadow_held == 0)
        begin
            r.valid = 1'b0;
            r.value = '0;
            r.prio  = '0;
            r.slot  = '0;
        end
        else
        begin
            best    = highest_slot();
            r.valid = 1'b1;
            r.value = shadow_store[AW'(best)].value;
            r.prio  = shadow_store[AW'(best)].prio;
            r.slot  = AW'(best);
        end
        return r;
    endfunction

    task automatic predict_word(input logic [1:0] cmd, input logic signed [31:0] val,
                                input logic signed [31:0] pri);
        upq_pkg::status_t st;
        int unsigned      best;
        st = upq_pkg::ST_DONE;
        if (cmd == upq_pkg::CMD_ENQUEUE)
        begin
            if (shadow_held >= DEPTH)
            begin
                st = upq_pkg::ST_OVERFLOW;
                overflows++;
            end
            else
            begin
                shadow_store[AW'(shadow_held)].value = val;
                shadow_store[AW'(shadow_held)].prio  = pri;
                shadow_held++;
            end
        end
        else if (cmd == upq_pkg::CMD_DEQUEUE)
        begin
            if (shadow_held == 0)
            begin
                st = upq_pkg::ST_UNDERFLOW;
                underflows++;
            end
            else
            begin
                // close up the slots above the removed entry, keeping arrival order
                best = highest_slot();
                for (int unsigned i = best; i + 1 < shadow_held; i++)
                    shadow_store[AW'(i)] = shadow_store[AW'(i + 1)];
                shadow_held--;
            end
        end
        awaited_reports.push_back(report_top(st));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_held = 0;
            awaited_reports.delete();
            pending = 0;
        end
        else
        begin
            // a result always belongs to a word taken earlier, so check it before taking a new word
            if (done)
            begin
                checked++;
                if (awaited_reports.size() == 0)
                    flag_mismatch("result with no word outstanding");
                else
                begin
                    oldest = awaited_reports.pop_front();
                    check_field("status", 32'(status), 32'(oldest.st));
                    check_field("top_valid", 32'(top_valid), 32'(oldest.valid));
                    check_field("top_value", top_value, oldest.value);
                    check_field("top_priority", top_priority, oldest.prio);
                    check_field("top_slot", 32'(top_slot), 32'(oldest.slot));
                    check_field("entry_count", 32'(entry_count), 32'(oldest.count));
                end
            end
            if (start && !busy)
                predict_word(command, item_value, item_priority);
            pending = awaited_reports.size();
        end
    end

endmodule

`default_nettype wire

[bench/unsorted_max_priority_queue_test.sv]
// Stimulus and verdict for the unsorted maximum priority queue.
`default_nettype none

module unsorted_max_priority_queue_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int RANDOM_WORDS = 1725;

    localparam logic [1:0]         CMD_UNUSED = 2'd3;
    localparam logic signed [31:0] INT_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT_MIN    = 32'sh8000_0000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           command = upq_pkg::CMD_PEEK;
    logic signed [31:0]   item_value = '0;
    logic signed [31:0]   item_priority = '0;
    logic                 done;
    logic [1:0]           status;
    logic                 top_valid;
    logic signed [31:0]   top_value;
    logic signed [31:0]   top_priority;
    logic [AW-1:0]        top_slot;
    logic [CW-1:0]        entry_count;

    int failures, pending, checked, overflows, underflows;

    int          idle_pct = 0;
    int          sent_enq = 0, sent_deq = 0, sent_other = 0;
    int unsigned fill_guess = 0;
    logic        filling = 1'b1;
    logic signed [31:0] tie_pool [4];

    unsorted_max_priority_queue #(.DEPTH(DEPTH)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .item_value    (item_value),
        .item_priority (item_priority),
        .done          (done),
        .status        (status),
        .top_valid     (top_valid),
        .top_value     (top_value),
        .top_priority  (top_priority),
        .top_slot      (top_slot),
        .entry_count   (entry_count)
    );

    upq_checker #(.DEPTH(DEPTH)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .item_value    (item_value),
        .item_priority (item_priority),
        .done          (done),
        .status        (status),
        .top_valid     (top_valid),
        .top_value     (top_value),
        .top_priority  (top_priority),
        .top_slot      (top_slot),
        .entry_count   (entry_count),
        .failures      (failures),
        .pending       (pending),
        .checked       (checked),
        .overflows     (overflows),
        .underflows    (underflows)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("unsorted_max_priority_queue_test failed");
        $finish;
    end

    // After idle gaps drawn from idle_pct, present one word on a falling edge and hold it until the queue takes it.
    task automatic drive_word(input logic [1:0] cmd, input logic signed [31:0] val,
                              input logic signed [31:0] pri);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start         <= 1'b0;
            item_value    <= $urandom;
            item_priority <= $urandom;
            @(negedge clk);
        end
        start         <= 1'b1;
        command       <= cmd;
        item_value    <= val;
        item_priority <= pri;
        do
            @(posedge clk);
        while (busy);
        if (cmd == upq_pkg::CMD_ENQUEUE)
        begin
            sent_enq++;
            if (fill_guess < DEPTH)
                fill_guess++;
        end
        else if (cmd == upq_pkg::CMD_DEQUEUE)
        begin
            sent_deq++;
            if (fill_guess > 0)
                fill_guess--;
        end
        else
            sent_other++;
    endtask

    function automatic logic signed [31:0] pick_priority();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            return tie_pool[2'($urandom_range(3))];
        if (r < 50)
        begin
            case ($urandom_range(3))
                0: return INT_MAX;
                1: return INT_MIN;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic random_word();
        int unsigned r;
        // swing between filling and draining so both full and empty are reached often
        if (fill_guess == DEPTH)
            filling = 1'b0;
        else if (fill_guess == 0)
            filling = 1'b1;
        else if ($urandom_range(39) == 0)
            filling = ~filling;
        r = $urandom_range(99);
        if (r < 4)
            drive_word(CMD_UNUSED, $urandom, $urandom);
        else if (r < 10)
            drive_word(upq_pkg::CMD_PEEK, $urandom, $urandom);
        else if ($urandom_range(99) < (filling ? 75 : 25))
            drive_word(upq_pkg::CMD_ENQUEUE, $urandom, pick_priority());
        else
            drive_word(upq_pkg::CMD_DEQUEUE, $urandom, $urandom);
    endtask

    initial
    begin
        int guard;
        for (int i = 0; i < 4; i++)
            tie_pool[2'(i)] = $urandom;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty queue: peek, underflow, unused code
        idle_pct = 29;
        drive_word(upq_pkg::CMD_PEEK, INT_MAX, INT_MIN);
        drive_word(upq_pkg::CMD_DEQUEUE, INT_MIN, INT_MAX);
        drive_word(CMD_UNUSED, 32'sd0, 32'sd0);
        // fill with extremes and ties, then overflow
        drive_word(upq_pkg::CMD_ENQUEUE, INT_MAX, 32'sd0);
        drive_word(upq_pkg::CMD_ENQUEUE, INT_MIN, INT_MIN);
        drive_word(upq_pkg::CMD_ENQUEUE, 32'sd0, INT_MAX);
        drive_word(upq_pkg::CMD_ENQUEUE, -32'sd1, INT_MAX);
        drive_word(upq_pkg::CMD_ENQUEUE, 32'sd5, -32'sd1);
        for (int i = 1; i <= 11; i++)
            drive_word(upq_pkg::CMD_ENQUEUE, 32'sh0101_0101 * i, (i % 3 == 0) ? 32'sd7 : -i);
        drive_word(upq_pkg::CMD_ENQUEUE, 32'sh5A5A_5A5A, INT_MAX);
        drive_word(upq_pkg::CMD_PEEK, 32'sd0, 32'sd0);
        drive_word(CMD_UNUSED, -32'sd1, -32'sd1);
        repeat (3)
            drive_word(upq_pkg::CMD_DEQUEUE, 32'sd0, 32'sd0);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS / 3)
                idle_pct = 77;
            else if (i == 2 * RANDOM_WORDS / 3)
                idle_pct = 0;
            if (i % 300 == 0)
                for (int k = 0; k < 4; k++)
                    tie_pool[2'(k)] = $urandom;
            random_word();
        end
        @(negedge clk);
        start <= 1'b0;

        guard = 0;
        while (pending != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DEPTH + 8) @(posedge clk);

        $display("%0d words sent: %0d enqueue, %0d dequeue, %0d peek or unused code",
                 sent_enq + sent_deq + sent_other, sent_enq, sent_deq, sent_other);
        $display("%0d results checked, %0d overflows and %0d underflows among them",
                 checked, overflows, underflows);
        if (pending != 0)
            $display("%0d results never arrived", pending);
        if (failures == 0 && pending == 0)
            $display("unsorted_max_priority_queue_test passed");
        else
            $display("unsorted_max_priority_queue_test failed");
        $finish;
    end

endmodule

`default_nettype wire
